// File: rtl/iiss_pkg.sv
package iiss_pkg;

    localparam int PIX_W     = 8;
    localparam int SUM_W     = 32;
    localparam int SQ_W      = 40;
    localparam int REG_W     = 13;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MAP_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } end_flags_t;

endpackage

// File: rtl/iiss_accum.sv
// Line-store read/modify/write: one read per accepted pixel, one write per result.
module iiss_accum #(
    parameter int ADDR_W = 12,
    parameter int RSUM_W = 20,
    parameter int RSQ_W  = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    output logic                          take_ready,
    input  logic [ADDR_W-1:0]             addr,
    input  logic                          first_row,
    input  logic [RSUM_W-1:0]             run_sum,
    input  logic [RSQ_W-1:0]              run_square,
    input  iiss_pkg::end_flags_t          flags_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [iiss_pkg::SUM_W-1:0]    integral_sum,
    output logic [iiss_pkg::SQ_W-1:0]     integral_square,
    output iiss_pkg::end_flags_t          flags_out
);

    localparam int DEPTH  = 1 << ADDR_W;
    localparam int WORD_W = iiss_pkg::SUM_W + iiss_pkg::SQ_W;

    logic [WORD_W-1:0] line_mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    logic                       s1_valid_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic                       s1_first_reg;
    logic [RSUM_W-1:0]          s1_sum_reg;
    logic [RSQ_W-1:0]           s1_sq_reg;
    iiss_pkg::end_flags_t       s1_flags_reg;
    logic                       fwd_hit_reg;
    logic [WORD_W-1:0]          fwd_data_reg;

    logic                       out_valid_reg;
    logic [iiss_pkg::SUM_W-1:0] out_sum_reg;
    logic [iiss_pkg::SQ_W-1:0]  out_sq_reg;
    iiss_pkg::end_flags_t       out_flags_reg;

    logic                       s1_move;
    logic [WORD_W-1:0]          above;
    logic [iiss_pkg::SUM_W-1:0] new_sum;
    logic [iiss_pkg::SQ_W-1:0]  new_sq;
    logic [WORD_W-1:0]          new_word;

    assign s1_move    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign take_ready = !s1_valid_reg || s1_move;

    // A write to the same entry at the read edge returns stale data; take the forwarded word.
    always_comb
    begin
        if (s1_first_reg)
            above = '0;
        else if (fwd_hit_reg)
            above = fwd_data_reg;
        else
            above = rd_data_reg;
        new_sum  = above[WORD_W-1 -: iiss_pkg::SUM_W] + iiss_pkg::SUM_W'(s1_sum_reg);
        new_sq   = above[iiss_pkg::SQ_W-1:0] + iiss_pkg::SQ_W'(s1_sq_reg);
        new_word = {new_sum, new_sq};
    end

    always_ff @(posedge clk)
    begin
        if (take)
            rd_data_reg <= line_mem[addr];
        if (s1_move)
            line_mem[s1_addr_reg] <= new_word;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_addr_reg  <= addr;
            s1_first_reg <= first_row;
            s1_sum_reg   <= run_sum;
            s1_sq_reg    <= run_square;
            s1_flags_reg <= flags_in;
            fwd_hit_reg  <= s1_move && (s1_addr_reg == addr);
            fwd_data_reg <= new_word;
        end
        if (s1_move)
        begin
            out_sum_reg   <= new_sum;
            out_sq_reg    <= new_sq;
            out_flags_reg <= s1_flags_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign integral_sum    = out_sum_reg;
    assign integral_square = out_sq_reg;
    assign flags_out       = out_flags_reg;

endmodule

// File: rtl/integral_image_sum_and_square_core.sv
// Channel | Dir | Handshake           | Payload
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
// in      | in  | in_valid/in_ready   | pixel
// out     | out | out_valid/out_ready | integral_sum, integral_square, row_end, frame_end
//
// One pixel per cycle unless the output stalls; a result passes the read and output registers.
// The line store is read into a register, then the add and write-back follow.
// Back-to-back hits on the same column (width one, or a shrink) are forwarded, not stalled.
// rst_n clears counters, running sums and valids; the line store is not cleared.
// A stalled output holds its result; one more pixel sits in the read stage before in_ready drops.
module integral_image_sum_and_square_core #(
    parameter int MAX_MAP_WIDTH  = 4096,
    parameter int MAX_MAP_HEIGHT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [iiss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [iiss_pkg::REG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [iiss_pkg::PIX_W-1:0]        pixel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [iiss_pkg::SUM_W-1:0]        integral_sum,
    output logic [iiss_pkg::SQ_W-1:0]         integral_square,
    output logic                              row_end,
    output logic                              frame_end
);

    localparam int COL_W  = $clog2(MAX_MAP_WIDTH);
    localparam int ROW_W  = $clog2(MAX_MAP_HEIGHT);
    localparam int CMPW_C = (COL_W + 1 > iiss_pkg::REG_W) ? COL_W + 1 : iiss_pkg::REG_W;
    localparam int CMPW_R = (ROW_W + 1 > iiss_pkg::REG_W) ? ROW_W + 1 : iiss_pkg::REG_W;
    localparam int RSUM_W = iiss_pkg::PIX_W + COL_W;
    localparam int RSQ_W  = 2 * iiss_pkg::PIX_W + COL_W;

    logic [iiss_pkg::REG_W-1:0] width_reg;
    logic [iiss_pkg::REG_W-1:0] height_reg;
    logic [COL_W-1:0]           col_reg;
    logic [COL_W-1:0]           col_next;
    logic [ROW_W-1:0]           row_reg;
    logic [ROW_W-1:0]           row_next;
    logic [RSUM_W-1:0]          rsum_reg;
    logic [RSUM_W-1:0]          rsum_next;
    logic [RSQ_W-1:0]           rsq_reg;
    logic [RSQ_W-1:0]           rsq_next;

    logic                       in_fire;
    logic [CMPW_C-1:0]          last_col_idx;
    logic [CMPW_R-1:0]          last_row_idx;
    logic [2*iiss_pkg::PIX_W-1:0] pix_sq;
    logic [RSUM_W-1:0]          run_sum;
    logic [RSQ_W-1:0]           run_sq;
    iiss_pkg::end_flags_t       flags;
    iiss_pkg::end_flags_t       flags_out;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    // Effective size minus one: zero acts as one, oversize saturates.
    always_comb
    begin
        if (width_reg == '0)
            last_col_idx = '0;
        else if (CMPW_C'(width_reg) > CMPW_C'(MAX_MAP_WIDTH))
            last_col_idx = CMPW_C'(MAX_MAP_WIDTH - 1);
        else
            last_col_idx = CMPW_C'(width_reg) - CMPW_C'(1);

        if (height_reg == '0)
            last_row_idx = '0;
        else if (CMPW_R'(height_reg) > CMPW_R'(MAX_MAP_HEIGHT))
            last_row_idx = CMPW_R'(MAX_MAP_HEIGHT - 1);
        else
            last_row_idx = CMPW_R'(height_reg) - CMPW_R'(1);
    end

    always_comb
    begin
        pix_sq          = (2*iiss_pkg::PIX_W)'(pixel) * (2*iiss_pkg::PIX_W)'(pixel);
        run_sum         = rsum_reg + RSUM_W'(pixel);
        run_sq          = rsq_reg + RSQ_W'(pix_sq);
        flags.row_end   = CMPW_C'(col_reg) >= last_col_idx;
        flags.frame_end = flags.row_end && (CMPW_R'(row_reg) >= last_row_idx);

        col_next  = col_reg;
        row_next  = row_reg;
        rsum_next = rsum_reg;
        rsq_next  = rsq_reg;
        if (in_fire)
        begin
            if (flags.row_end)
            begin
                col_next  = '0;
                rsum_next = '0;
                rsq_next  = '0;
                row_next  = flags.frame_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next  = col_reg + COL_W'(1);
                rsum_next = run_sum;
                rsq_next  = run_sq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= iiss_pkg::REG_W'(4096);
            height_reg <= iiss_pkg::REG_W'(4096);
            col_reg    <= '0;
            row_reg    <= '0;
            rsum_reg   <= '0;
            rsq_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    iiss_pkg::CFG_MAP_WIDTH:  width_reg  <= cfg_data;
                    iiss_pkg::CFG_MAP_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            col_reg  <= col_next;
            row_reg  <= row_next;
            rsum_reg <= rsum_next;
            rsq_reg  <= rsq_next;
        end
    end

    iiss_accum #(
        .ADDR_W (COL_W),
        .RSUM_W (RSUM_W),
        .RSQ_W  (RSQ_W)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (in_fire),
        .take_ready      (in_ready),
        .addr            (col_reg),
        .first_row       (row_reg == '0),
        .run_sum         (run_sum),
        .run_square      (run_sq),
        .flags_in        (flags),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .integral_sum    (integral_sum),
        .integral_square (integral_square),
        .flags_out       (flags_out)
    );

    assign row_end   = flags_out.row_end;
    assign frame_end = flags_out.frame_end;

endmodule

// File: rtl/iiss_props.sv
module iiss_props (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [iiss_pkg::SUM_W-1:0]     integral_sum,
    input logic [iiss_pkg::SQ_W-1:0]      integral_square,
    input logic                           row_end,
    input logic                           frame_end
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(integral_sum)
            && $stable(integral_square) && $stable(row_end) && $stable(frame_end))
        else $error("result changed while stalled");

    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame end without row end");

    // With the output side empty, the pipe always has room for a pixel.
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output empty");

    // No result appears without an earlier pixel transfer in or an already valid result.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(in_valid && in_ready) && !$past(in_valid && in_ready, 2) && !$past(out_valid)
            |-> !out_valid)
        else $error("result without a pixel transfer");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind integral_image_sum_and_square_core iiss_props u_iiss_props (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .integral_sum    (integral_sum),
    .integral_square (integral_square),
    .row_end         (row_end),
    .frame_end       (frame_end)
);

// File: tb/tb_integral_image_sum_and_square_core.sv
module tb_integral_image_sum_and_square_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = 4096;
    localparam int MAX_H         = 4096;
    localparam int RANDOM_PIXELS = 1700;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRINT_CAP     = 100;

    // index values the block does not decode; writes there must change nothing
    localparam logic [iiss_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [iiss_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [iiss_pkg::SUM_W-1:0] sum;
        logic [iiss_pkg::SQ_W-1:0]  square;
        iiss_pkg::end_flags_t       ends;
    } sat_result_t;

    typedef enum logic {
        STEP_PIXEL,
        STEP_REG
    } step_kind_t;

    typedef struct packed {
        step_kind_t                     kind;
        logic [iiss_pkg::CFG_IDX_W-1:0] idx;
        logic [iiss_pkg::REG_W-1:0]     value;
        logic                           typed;
        logic [iiss_pkg::SUM_W-1:0]     x_sum;
        logic [iiss_pkg::SQ_W-1:0]      x_square;
        logic                           x_row_end;
        logic                           x_frame_end;
    } plan_row_t;

    localparam int PLAN_LEN = 32;

    plan_row_t plan [PLAN_LEN] = '{
        '{STEP_PIXEL, '0, 13'd255, 1'b1, 32'd255, 40'd65025, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd0, 1'b1, 32'd255, 40'd65025, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd1, 1'b0, '0, '0, 1'b0, 1'b0},
        // zero sizes act as 1: the shrink closes row and map on the next pixel
        '{STEP_REG, iiss_pkg::CFG_MAP_WIDTH, 13'd0, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_REG, iiss_pkg::CFG_MAP_HEIGHT, 13'd0, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd255, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd255, 1'b1, 32'd255, 40'd65025, 1'b1, 1'b1},
        '{STEP_REG, iiss_pkg::CFG_MAP_HEIGHT, 13'd2, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd200, 1'b1, 32'd200, 40'd40000, 1'b1, 1'b0},
        '{STEP_PIXEL, '0, 13'd255, 1'b1, 32'd455, 40'd105025, 1'b1, 1'b1},
        // all-ones saturates to the maximum
        '{STEP_REG, iiss_pkg::CFG_MAP_WIDTH, 13'd8191, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_REG, iiss_pkg::CFG_MAP_HEIGHT, 13'd8191, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd128, 1'b1, 32'd128, 40'd16384, 1'b0, 1'b0},
        '{STEP_REG, iiss_pkg::CFG_MAP_WIDTH, 13'd3, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_REG, REG_SPARE_2, 13'd8191, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_REG, REG_SPARE_3, 13'd0, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_REG, iiss_pkg::CFG_MAP_HEIGHT, 13'd4097, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd255, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd255, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd255, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd0, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd255, 1'b0, '0, '0, 1'b0, 1'b0},
        // height shrink below the current row: map ends with this row
        '{STEP_REG, iiss_pkg::CFG_MAP_HEIGHT, 13'd2, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd7, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd255, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd255, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_REG, iiss_pkg::CFG_MAP_WIDTH, 13'd4097, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd255, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd0, 1'b0, '0, '0, 1'b0, 1'b0},
        // width shrink below the current column ends the row at once
        '{STEP_REG, iiss_pkg::CFG_MAP_WIDTH, 13'd1, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd9, 1'b0, '0, '0, 1'b0, 1'b0},
        '{STEP_PIXEL, '0, 13'd255, 1'b0, '0, '0, 1'b0, 1'b0}
    };

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [iiss_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [iiss_pkg::REG_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [iiss_pkg::PIX_W-1:0]     pixel;
    logic                           out_valid;
    logic                           out_ready;
    logic [iiss_pkg::SUM_W-1:0]     integral_sum;
    logic [iiss_pkg::SQ_W-1:0]      integral_square;
    logic                           row_end;
    logic                           frame_end;

    // predictor state
    logic [iiss_pkg::REG_W-1:0] width_reg;
    logic [iiss_pkg::REG_W-1:0] height_reg;
    logic [iiss_pkg::SUM_W-1:0] line_sum    [MAX_W];
    logic [iiss_pkg::SQ_W-1:0]  line_square [MAX_W];
    logic [19:0]                row_run_sum;
    logic [27:0]                row_run_square;
    logic [11:0]                col_pos;
    logic [11:0]                row_pos;
    int                         cols_written;

    sat_result_t sat_expected_q [$];
    int          mismatches;
    int          idle_cycles;
    bit          in_calm;
    bit          out_calm;
    bit          long_hold_req;

    integral_image_sum_and_square_core #(
        .MAX_MAP_WIDTH  (MAX_W),
        .MAX_MAP_HEIGHT (MAX_H)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel           (pixel),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .integral_sum    (integral_sum),
        .integral_square (integral_square),
        .row_end         (row_end),
        .frame_end       (frame_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [iiss_pkg::REG_W-1:0] clamp_size(
        input logic [iiss_pkg::REG_W-1:0] r, input int lim);
        if (r == '0)
            return 13'd1;
        if (int'(r) > lim)
            return lim[iiss_pkg::REG_W-1:0];
        return r;
    endfunction

    function automatic void apply_reg(input logic [iiss_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [iiss_pkg::REG_W-1:0] data);
        if (idx == iiss_pkg::CFG_MAP_WIDTH)
            width_reg = data;
        else if (idx == iiss_pkg::CFG_MAP_HEIGHT)
            height_reg = data;
    endfunction

    // advance the summed-area state by one pixel and return its result
    function automatic sat_result_t step_sat(input logic [iiss_pkg::PIX_W-1:0] p);
        logic [iiss_pkg::REG_W-1:0] w;
        logic [iiss_pkg::REG_W-1:0] h;
        logic [iiss_pkg::SUM_W-1:0] above_sum;
        logic [iiss_pkg::SQ_W-1:0]  above_square;
        logic [15:0]                p_sq;
        logic                       last_row;
        logic                       last_map;
        sat_result_t                r;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, MAX_H);
        p_sq = 16'(p) * 16'(p);
        row_run_sum = row_run_sum + 20'(p);
        row_run_square = row_run_square + 28'(p_sq);
        above_sum = '0;
        above_square = '0;
        if (row_pos != '0)
        begin
            above_sum = line_sum[col_pos];
            above_square = line_square[col_pos];
        end
        r.sum = iiss_pkg::SUM_W'(row_run_sum) + above_sum;
        r.square = iiss_pkg::SQ_W'(row_run_square) + above_square;
        line_sum[col_pos] = r.sum;
        line_square[col_pos] = r.square;
        if (int'(col_pos) + 1 > cols_written)
            cols_written = int'(col_pos) + 1;
        last_row = {1'b0, col_pos} >= w - 13'd1;
        last_map = last_row && ({1'b0, row_pos} >= h - 13'd1);
        r.ends.row_end = last_row;
        r.ends.frame_end = last_map;
        if (last_row)
        begin
            col_pos = '0;
            row_run_sum = '0;
            row_run_square = '0;
            row_pos = last_map ? 12'd0 : row_pos + 12'd1;
        end
        else
            col_pos = col_pos + 12'd1;
        return r;
    endfunction

    // a wider row may only be read where some earlier row has written
    function automatic bit width_write_safe(input logic [iiss_pkg::REG_W-1:0] data);
        return row_pos == '0 || int'(clamp_size(data, MAX_W)) <= cols_written;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [iiss_pkg::REG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return iiss_pkg::REG_W'($urandom_range(1, 8));
        if (r < 85)
            return iiss_pkg::REG_W'($urandom_range(9, 40));
        if (r < 90)
            return 13'd0;
        if (r < 94)
            return 13'd8191;
        if (r < 97)
            return iiss_pkg::REG_W'($urandom_range(4096, 4097));
        return iiss_pkg::REG_W'($urandom_range(0, 8191));
    endfunction

    function automatic logic [iiss_pkg::PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 8'd0;
        if (r < 24)
            return 8'd255;
        return iiss_pkg::PIX_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_pixel(input logic [iiss_pkg::PIX_W-1:0] p, input bit typed,
                              input sat_result_t want);
        int          gap;
        sat_result_t predicted;
        gap = pick_gap(in_calm);
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= p;
        do @(negedge clk); while (!in_ready);
        predicted = step_sat(p);
        sat_expected_q.push_back(typed ? want : predicted);
        @(posedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input logic [iiss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [iiss_pkg::REG_W-1:0] data);
        in_valid <= 1'b0;
        if (sat_expected_q.size() != 0)
        begin
            cfg_valid <= 1'b0;
            while (sat_expected_q.size() != 0) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(negedge clk); while (!cfg_ready);
        apply_reg(idx, data);
        @(posedge clk);
    endtask

    initial
    begin : drive_out_ready
        int gap;
        out_ready = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                gap = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else
                gap = pick_gap(out_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(negedge clk)
    begin : check_results
        sat_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sat_expected_q.size() == 0)
                report_mismatch("result with none pending", 64'(integral_sum), 64'(0));
            else
            begin
                want = sat_expected_q.pop_front();
                if (integral_sum !== want.sum)
                    report_mismatch("integral_sum", 64'(integral_sum), 64'(want.sum));
                if (integral_square !== want.square)
                    report_mismatch("integral_square", 64'(integral_square),
                                    64'(want.square));
                if (row_end !== want.ends.row_end)
                    report_mismatch("row_end", 64'(row_end), 64'(want.ends.row_end));
                if (frame_end !== want.ends.frame_end)
                    report_mismatch("frame_end", 64'(frame_end), 64'(want.ends.frame_end));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("[integral_image_sum_and_square_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int                         phase;
        int                         sent;
        int                         burst;
        int                         span;
        int                         choice;
        logic [iiss_pkg::REG_W-1:0] cand_width;
        logic [iiss_pkg::REG_W-1:0] cand_height;
        sat_result_t                want;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel = '0;
        mismatches = 0;
        in_calm = 1'b0;
        out_calm = 1'b0;
        long_hold_req = 1'b0;
        width_reg = 13'd4096;
        height_reg = 13'd4096;
        row_run_sum = '0;
        row_run_square = '0;
        col_pos = '0;
        row_pos = '0;
        cols_written = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_REG)
                write_reg(plan[i].idx, plan[i].value);
            else
            begin
                want.sum = plan[i].x_sum;
                want.square = plan[i].x_square;
                want.ends.row_end = plan[i].x_row_end;
                want.ends.frame_end = plan[i].x_frame_end;
                send_pixel(plan[i].value[iiss_pkg::PIX_W-1:0], plan[i].typed, want);
            end
        end

        phase = 0;
        sent = 0;
        want = '0;
        while (sent < RANDOM_PIXELS)
        begin
            phase++;
            in_calm = ($urandom_range(0, 4) == 0);
            out_calm = ($urandom_range(0, 4) == 0);
            choice = $urandom_range(0, 9);
            cand_width = pick_size();
            cand_height = pick_size();
            if (choice <= 7 && width_write_safe(cand_width))
                write_reg(iiss_pkg::CFG_MAP_WIDTH, cand_width);
            if (choice <= 5 || choice == 8)
                write_reg(iiss_pkg::CFG_MAP_HEIGHT, cand_height);
            span = int'(clamp_size(width_reg, MAX_W)) * int'(clamp_size(height_reg, MAX_H));
            burst = $urandom_range(1, (3 * span < 64) ? 3 * span : 64);
            // one long output stall while pixels keep coming, to back up the pipe
            if (phase == 3)
            begin
                long_hold_req = 1'b1;
                in_calm = 1'b1;
                burst = 48;
            end
            repeat (burst) send_pixel(pick_pixel(), 1'b0, want);
            sent += burst;
        end

        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (sat_expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[integral_image_sum_and_square_core] OK");
        else
            $display("[integral_image_sum_and_square_core] ERROR");
        $finish;
    end

endmodule
